// File: design/hkep_pkg.sv
`timescale 1ns / 1ps

package hkep_pkg;

    // Special keycodes.
    localparam logic [15:0] KC_MEDIA_FIRST  = 16'h00A8;
    localparam logic [15:0] KC_MEDIA_LAST   = 16'h00AE;
    localparam logic [15:0] KC_ANIM_TOGGLE  = 16'h7823;
    localparam logic [15:0] KC_MACRO        = 16'h7700;
    localparam logic [15:0] KC_GUI_TOGGLE   = 16'h700B;
    localparam logic [15:0] KC_PATTERN_LEFT = 16'h7821;
    localparam logic [15:0] KC_PATTERN_RIGHT = 16'h7822;
    localparam logic [15:0] KC_BRIGHT_DOWN  = 16'h7803;
    localparam logic [15:0] KC_BRIGHT_UP    = 16'h7804;
    localparam logic [15:0] KC_FN           = 16'h5220;
    localparam logic [15:0] KC_FN_LOCK      = 16'h5260;
    localparam logic [15:0] KC_MOD_FIRST    = 16'h00E0;
    localparam logic [15:0] KC_MOD_LAST     = 16'h00E7;
    localparam logic [2:0]  MOD_LEFT_GUI    = 3'd3;
    localparam logic [2:0]  MOD_RIGHT_GUI   = 3'd7;

    localparam int KEY_SLOTS_DEFAULT = 6;
    localparam int REPORT_SLOTS      = 6;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int          ADDR_W               = 3;
    localparam logic        REG_PATTERN_COUNT    = 1'b0;
    localparam logic [4:0]  PATTERN_COUNT_RESET  = 5'd8;
    localparam logic [4:0]  PATTERN_COUNT_MAX    = 5'd16;

    localparam logic [1:0] BRIGHT_NONE = 2'd0;
    localparam logic [1:0] BRIGHT_DOWN = 2'd1;
    localparam logic [1:0] BRIGHT_UP   = 2'd2;

    typedef enum logic [3:0] {
        OP_MEDIA,
        OP_ANIM,
        OP_MACRO,
        OP_GUI,
        OP_PAT_LEFT,
        OP_PAT_RIGHT,
        OP_BRI_DOWN,
        OP_BRI_UP,
        OP_FN,
        OP_FN_LOCK,
        OP_MOD,
        OP_MOD_GUI,
        OP_KEY
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] bit_idx;
        logic [7:0] key_byte;
        logic       key_small;
        logic       pressed;
    } cmd_t;

    typedef struct packed {
        logic [15:0] keycode;
        logic        pressed;
    } event_t;

    typedef struct packed {
        logic [7:0]  report_modifiers;
        logic [47:0] report_keys;
        logic [6:0]  report_media;
        logic        keyboard_report_due;
        logic        media_report_due;
        logic [2:0]  layer_index;
        logic [3:0]  current_pattern;
        logic        pattern_load;
        logic [1:0]  brightness_step;
        logic        animation_state;
        logic        gui_state;
        logic        led_refresh;
    } result_t;

endpackage

// File: design/hkep_front.sv
`timescale 1ns / 1ps

module hkep_front (
    input  logic            in_valid,
    input  hkep_pkg::event_t in_word,
    input  logic            queue_full,
    output logic            in_stall,
    output logic            push,
    output hkep_pkg::cmd_t  cmd
);

    logic [15:0] kc;

    assign kc       = in_word.keycode;
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        cmd.bit_idx   = kc[2:0];
        cmd.key_byte  = kc[7:0];
        cmd.key_small = (kc[15:8] == 8'h00);
        cmd.pressed   = in_word.pressed;
        unique case (kc)
            hkep_pkg::KC_ANIM_TOGGLE:   cmd.op = hkep_pkg::OP_ANIM;
            hkep_pkg::KC_MACRO:         cmd.op = hkep_pkg::OP_MACRO;
            hkep_pkg::KC_GUI_TOGGLE:    cmd.op = hkep_pkg::OP_GUI;
            hkep_pkg::KC_PATTERN_LEFT:  cmd.op = hkep_pkg::OP_PAT_LEFT;
            hkep_pkg::KC_PATTERN_RIGHT: cmd.op = hkep_pkg::OP_PAT_RIGHT;
            hkep_pkg::KC_BRIGHT_DOWN:   cmd.op = hkep_pkg::OP_BRI_DOWN;
            hkep_pkg::KC_BRIGHT_UP:     cmd.op = hkep_pkg::OP_BRI_UP;
            hkep_pkg::KC_FN:            cmd.op = hkep_pkg::OP_FN;
            hkep_pkg::KC_FN_LOCK:       cmd.op = hkep_pkg::OP_FN_LOCK;
            default:
            begin
                if (kc >= hkep_pkg::KC_MEDIA_FIRST && kc <= hkep_pkg::KC_MEDIA_LAST)
                    cmd.op = hkep_pkg::OP_MEDIA;
                else if (kc >= hkep_pkg::KC_MOD_FIRST && kc <= hkep_pkg::KC_MOD_LAST)
                begin
                    if (kc[2:0] == hkep_pkg::MOD_LEFT_GUI || kc[2:0] == hkep_pkg::MOD_RIGHT_GUI)
                        cmd.op = hkep_pkg::OP_MOD_GUI;
                    else
                        cmd.op = hkep_pkg::OP_MOD;
                end
                else
                    cmd.op = hkep_pkg::OP_KEY;
            end
        endcase
    end

endmodule

// File: design/hkep_queue.sv
`timescale 1ns / 1ps

module hkep_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hkep_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output hkep_pkg::cmd_t head_cmd
);

    hkep_pkg::cmd_t                       mem [hkep_pkg::QUEUE_DEPTH];
    logic [hkep_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [hkep_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [hkep_pkg::QUEUE_CNT_W-1:0]     count_reg, count_next;
    logic                                 do_push, do_pop;

    localparam logic [hkep_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        hkep_pkg::QUEUE_PTR_W'(hkep_pkg::QUEUE_DEPTH - 1);
    localparam logic [hkep_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        hkep_pkg::QUEUE_CNT_W'(hkep_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: design/hkep_back.sv
`timescale 1ns / 1ps

module hkep_back #(
    parameter int KEY_SLOTS = hkep_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  hkep_pkg::cmd_t    cmd,
    input  logic [4:0]        pattern_count,
    input  logic              out_stall,
    output logic              pop,
    output logic              out_valid,
    output hkep_pkg::result_t out_word
);

    logic [7:0] slots_reg [KEY_SLOTS];
    logic [7:0] slots_next [KEY_SLOTS];
    logic [7:0] mods_reg, mods_next;
    logic [6:0] media_reg, media_next;
    logic       fn_lock_reg, fn_lock_next;
    logic       fn_held_reg, fn_held_next;
    logic       macro_reg, macro_next;
    logic       gui_reg, gui_next;
    logic [3:0] pattern_reg, pattern_next;
    logic       anim_reg, anim_next;
    logic       out_valid_reg;
    hkep_pkg::result_t out_word_reg, result;

    logic                 advance;
    logic                 on;
    logic [KEY_SLOTS-1:0] slot_sel;
    logic                 slot_hit;
    logic [4:0]           count_clip;
    logic [3:0]           limit;
    logic [7:0]           mod_mask;
    logic [6:0]           media_mask;

    assign advance   = !out_valid_reg || !out_stall;
    assign pop       = cmd_valid && advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign on        = cmd.pressed;
    assign mod_mask  = 8'b1 << cmd.bit_idx;
    assign media_mask = mod_mask[6:0];

    always_comb
    begin
        if (pattern_count > hkep_pkg::PATTERN_COUNT_MAX)
            count_clip = hkep_pkg::PATTERN_COUNT_MAX;
        else if (pattern_count == 5'd0)
            count_clip = 5'd1;
        else
            count_clip = pattern_count;
    end

    assign limit = 4'(count_clip - 5'd1);

    // First empty slot on a press, first matching slot on a release.
    always_comb
    begin
        slot_hit = 1'b0;
        slot_sel = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (!slot_hit && (on ? (slots_reg[i] == 8'h00)
                                 : (cmd.key_small && slots_reg[i] == cmd.key_byte)))
            begin
                slot_sel[i] = 1'b1;
                slot_hit    = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
            slots_next[i] = slots_reg[i];
        mods_next    = mods_reg;
        media_next   = media_reg;
        fn_lock_next = fn_lock_reg;
        fn_held_next = fn_held_reg;
        macro_next   = macro_reg;
        gui_next     = gui_reg;
        pattern_next = pattern_reg;
        anim_next    = anim_reg;
        result       = '0;
        result.brightness_step = hkep_pkg::BRIGHT_NONE;

        case (cmd.op) inside
            hkep_pkg::OP_MEDIA:
            begin
                media_next = on ? (media_reg | media_mask) : (media_reg & ~media_mask);
                result.media_report_due = 1'b1;
            end
            hkep_pkg::OP_ANIM:
                if (on)
                    anim_next = !anim_reg;
            hkep_pkg::OP_MACRO:
            begin
                macro_next = on;
                result.led_refresh = 1'b1;
            end
            hkep_pkg::OP_GUI:
                if (on)
                    gui_next = !gui_reg;
            hkep_pkg::OP_PAT_LEFT:
                if (on && pattern_reg != 4'd0)
                begin
                    pattern_next = pattern_reg - 4'd1;
                    result.pattern_load = 1'b1;
                end
            hkep_pkg::OP_PAT_RIGHT:
                if (on && pattern_reg < limit)
                begin
                    pattern_next = pattern_reg + 4'd1;
                    result.pattern_load = 1'b1;
                end
            hkep_pkg::OP_BRI_DOWN:
                if (on)
                    result.brightness_step = hkep_pkg::BRIGHT_DOWN;
            hkep_pkg::OP_BRI_UP:
                if (on)
                    result.brightness_step = hkep_pkg::BRIGHT_UP;
            hkep_pkg::OP_FN:
            begin
                fn_held_next = on;
                if (!on)
                    macro_next = 1'b0;
                result.led_refresh = 1'b1;
            end
            hkep_pkg::OP_FN_LOCK:
                if (on)
                begin
                    fn_lock_next = !fn_lock_reg;
                    result.led_refresh = 1'b1;
                end
            hkep_pkg::OP_MOD, hkep_pkg::OP_MOD_GUI:
                if (cmd.op == hkep_pkg::OP_MOD || gui_reg)
                begin
                    mods_next = on ? (mods_reg | mod_mask) : (mods_reg & ~mod_mask);
                    result.keyboard_report_due = 1'b1;
                end
            default:
            begin
                for (int i = 0; i < KEY_SLOTS; i++)
                    if (slot_sel[i])
                        slots_next[i] = on ? cmd.key_byte : 8'h00;
                result.keyboard_report_due = slot_hit;
            end
        endcase

        result.report_modifiers = mods_next;
        for (int i = 0; i < hkep_pkg::REPORT_SLOTS; i++)
            if (i < KEY_SLOTS)
                result.report_keys[8*i +: 8] = slots_next[i];
        result.report_media    = media_next;
        result.layer_index     = 3'(fn_lock_next) + {1'b0, fn_held_next, 1'b0}
                                 + {1'b0, macro_next, 1'b0};
        result.current_pattern = pattern_next;
        result.animation_state = anim_next;
        result.gui_state       = gui_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
                slots_reg[i] <= 8'h00;
            mods_reg      <= '0;
            media_reg     <= '0;
            fn_lock_reg   <= 1'b0;
            fn_held_reg   <= 1'b0;
            macro_reg     <= 1'b0;
            gui_reg       <= 1'b1;
            pattern_reg   <= '0;
            anim_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= cmd_valid;
            if (pop)
            begin
                for (int i = 0; i < KEY_SLOTS; i++)
                    slots_reg[i] <= slots_next[i];
                mods_reg    <= mods_next;
                media_reg   <= media_next;
                fn_lock_reg <= fn_lock_next;
                fn_held_reg <= fn_held_next;
                macro_reg   <= macro_next;
                gui_reg     <= gui_next;
                pattern_reg <= pattern_next;
                anim_reg    <= anim_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_word_reg <= result;
    end

endmodule

// File: design/hid_keyboard_event_processor_unit.sv
`timescale 1ns / 1ps

// Keyboard event processor: one key event word in, one report word out.
// Input channel in_valid / in_stall / in_word carries a keycode and a
// pressed flag. Output channel out_valid / out_stall / out_word carries the
// modifier, key-slot and media reports, the layer index and LED action strobes.
// A classifier decodes each accepted word into a command and writes it into a
// two-entry queue; an executor takes one command per cycle unless the output
// stalls, updates the key state and loads the result into the output register.
// With an idle output, out_valid rises once the word has passed the queue and
// the output register. Throughput is one word per cycle while out_stall is low.
// When the receiver stalls, the output register holds its word, the queue
// fills, and in_stall rises once both queue entries are taken.
// Reset empties all key slots and maps, clears layer, pattern and animation
// state, enables GUI keys and sets pattern_count to 8. The APB port holds
// pattern_count at byte address 0; write it only while the block is idle.

module hid_keyboard_event_processor_unit #(
    parameter int KEY_SLOTS = hkep_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  hkep_pkg::event_t            in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output hkep_pkg::result_t           out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hkep_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [4:0]     pattern_count_reg;
    logic           push, pop, queue_full, queue_not_empty;
    hkep_pkg::cmd_t front_cmd, head_cmd;
    logic           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[hkep_pkg::ADDR_W-1] == hkep_pkg::REG_PATTERN_COUNT);
    assign prdata  = reg_sel ? {27'd0, pattern_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pattern_count_reg <= hkep_pkg::PATTERN_COUNT_RESET;
        else if (psel && penable && pwrite && reg_sel)
            pattern_count_reg <= pwdata[4:0];
    end

    hkep_front u_front (
        .in_valid   (in_valid),
        .in_word    (in_word),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .cmd        (front_cmd)
    );

    hkep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    hkep_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (queue_not_empty),
        .cmd           (head_cmd),
        .pattern_count (pattern_count_reg),
        .out_stall     (out_stall),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_word      (out_word)
    );

endmodule

// File: verif/tb_hid_keyboard_event_processor_unit.sv
`timescale 1ns / 1ps

module tb_hid_keyboard_event_processor_unit;

    localparam logic [hkep_pkg::ADDR_W-1:0] PATTERN_COUNT_ADDR =
        hkep_pkg::ADDR_W'(int'(hkep_pkg::REG_PATTERN_COUNT) * 4);
    localparam int RANDOM_PER_PHASE = 60;

    // Tracks the keyboard state and holds the reports that the block still owes.
    class report_tracker;
        logic [4:0] pattern_count;
        logic [7:0] modifiers;
        logic [7:0] slots [hkep_pkg::REPORT_SLOTS];
        logic [6:0] media;
        logic       fn_lock;
        logic       fn_held;
        logic       macro_held;
        logic       gui_enabled;
        logic [3:0] pattern;
        logic       animation;
        hkep_pkg::result_t expected_reports [$];
        int         errors;

        function new();
            pattern_count = hkep_pkg::PATTERN_COUNT_RESET;
            modifiers     = '0;
            foreach (slots[i])
                slots[i] = '0;
            media       = '0;
            fn_lock     = 1'b0;
            fn_held     = 1'b0;
            macro_held  = 1'b0;
            gui_enabled = 1'b1;
            pattern     = '0;
            animation   = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void note_event(hkep_pkg::event_t ev);
            hkep_pkg::result_t r;
            logic [15:0] kc;
            logic        on;
            logic [4:0]  cnt;
            logic [3:0]  lim;
            logic [2:0]  idx;
            r  = '0;
            kc = ev.keycode;
            on = ev.pressed;
            if (kc >= hkep_pkg::KC_MEDIA_FIRST && kc <= hkep_pkg::KC_MEDIA_LAST)
            begin
                media[kc - hkep_pkg::KC_MEDIA_FIRST] = on;
                r.media_report_due = 1'b1;
            end
            else if (kc == hkep_pkg::KC_ANIM_TOGGLE)
            begin
                if (on)
                    animation = !animation;
            end
            else if (kc == hkep_pkg::KC_MACRO)
            begin
                macro_held    = on;
                r.led_refresh = 1'b1;
            end
            else if (kc == hkep_pkg::KC_GUI_TOGGLE)
            begin
                if (on)
                    gui_enabled = !gui_enabled;
            end
            else if (kc == hkep_pkg::KC_PATTERN_LEFT)
            begin
                if (on && pattern != 0)
                begin
                    pattern        = pattern - 1'b1;
                    r.pattern_load = 1'b1;
                end
            end
            else if (kc == hkep_pkg::KC_PATTERN_RIGHT)
            begin
                cnt = pattern_count;
                if (cnt > hkep_pkg::PATTERN_COUNT_MAX)
                    cnt = hkep_pkg::PATTERN_COUNT_MAX;
                if (cnt == 0)
                    cnt = 5'd1;
                lim = 4'(cnt - 1'b1);
                if (on && pattern < lim)
                begin
                    pattern        = pattern + 1'b1;
                    r.pattern_load = 1'b1;
                end
            end
            else if (kc == hkep_pkg::KC_BRIGHT_DOWN)
            begin
                if (on)
                    r.brightness_step = hkep_pkg::BRIGHT_DOWN;
            end
            else if (kc == hkep_pkg::KC_BRIGHT_UP)
            begin
                if (on)
                    r.brightness_step = hkep_pkg::BRIGHT_UP;
            end
            else if (kc == hkep_pkg::KC_FN)
            begin
                fn_held = on;
                if (!on)
                    macro_held = 1'b0;
                r.led_refresh = 1'b1;
            end
            else if (kc == hkep_pkg::KC_FN_LOCK)
            begin
                if (on)
                begin
                    fn_lock       = !fn_lock;
                    r.led_refresh = 1'b1;
                end
            end
            else if (kc >= hkep_pkg::KC_MOD_FIRST && kc <= hkep_pkg::KC_MOD_LAST)
            begin
                idx = kc[2:0];
                if ((idx != hkep_pkg::MOD_LEFT_GUI && idx != hkep_pkg::MOD_RIGHT_GUI)
                    || gui_enabled)
                begin
                    modifiers[idx]        = on;
                    r.keyboard_report_due = 1'b1;
                end
            end
            else
            begin
                // A press takes the first empty slot; a release frees the first
                // slot holding the code, and only codes below 256 can match.
                for (int i = 0; i < hkep_pkg::REPORT_SLOTS; i++)
                begin
                    if (on)
                    begin
                        if (slots[i] == 0)
                        begin
                            slots[i]              = kc[7:0];
                            r.keyboard_report_due = 1'b1;
                            break;
                        end
                    end
                    else if (kc < 16'd256 && slots[i] == kc[7:0])
                    begin
                        slots[i]              = '0;
                        r.keyboard_report_due = 1'b1;
                        break;
                    end
                end
            end

            r.report_modifiers = modifiers;
            for (int i = 0; i < hkep_pkg::REPORT_SLOTS; i++)
                r.report_keys[8*i +: 8] = slots[i];
            r.report_media    = media;
            r.layer_index     = 3'(fn_lock) + 3'(2 * fn_held) + 3'(2 * macro_held);
            r.current_pattern = pattern;
            r.animation_state = animation;
            r.gui_state       = gui_enabled;
            expected_reports.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_report(hkep_pkg::result_t got);
            hkep_pkg::result_t want;
            if (expected_reports.size() == 0)
            begin
                report("unexpected word", 64'(got.report_keys), '0);
                return;
            end
            want = expected_reports.pop_front();
            if (got.report_modifiers != want.report_modifiers)
                report("report_modifiers", 64'(got.report_modifiers),
                       64'(want.report_modifiers));
            if (got.report_keys != want.report_keys)
                report("report_keys", 64'(got.report_keys), 64'(want.report_keys));
            if (got.report_media != want.report_media)
                report("report_media", 64'(got.report_media), 64'(want.report_media));
            if (got.keyboard_report_due != want.keyboard_report_due)
                report("keyboard_report_due", 64'(got.keyboard_report_due),
                       64'(want.keyboard_report_due));
            if (got.media_report_due != want.media_report_due)
                report("media_report_due", 64'(got.media_report_due),
                       64'(want.media_report_due));
            if (got.layer_index != want.layer_index)
                report("layer_index", 64'(got.layer_index), 64'(want.layer_index));
            if (got.current_pattern != want.current_pattern)
                report("current_pattern", 64'(got.current_pattern),
                       64'(want.current_pattern));
            if (got.pattern_load != want.pattern_load)
                report("pattern_load", 64'(got.pattern_load), 64'(want.pattern_load));
            if (got.brightness_step != want.brightness_step)
                report("brightness_step", 64'(got.brightness_step),
                       64'(want.brightness_step));
            if (got.animation_state != want.animation_state)
                report("animation_state", 64'(got.animation_state),
                       64'(want.animation_state));
            if (got.gui_state != want.gui_state)
                report("gui_state", 64'(got.gui_state), 64'(want.gui_state));
            if (got.led_refresh != want.led_refresh)
                report("led_refresh", 64'(got.led_refresh), 64'(want.led_refresh));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    hkep_pkg::event_t            in_word;
    logic                        out_valid;
    logic                        out_stall;
    hkep_pkg::result_t           out_word;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [hkep_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    report_tracker tracker;
    logic          send_steady;
    logic          recv_steady;

    hid_keyboard_event_processor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
        clk = 1'b0;

    always
        #5 clk = ~clk;

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // Sender: an optional gap, then the word is held until the block takes it.
    task automatic send_event(hkep_pkg::event_t ev);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= ev;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_event(ev);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pattern_count(logic [4:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PATTERN_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.pattern_count = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic hkep_pkg::event_t random_event();
        hkep_pkg::event_t ev;
        int          pick;
        logic [7:0]  pool_key;
        logic [15:0] specials [10];
        specials = '{hkep_pkg::KC_ANIM_TOGGLE, hkep_pkg::KC_MACRO,
                     hkep_pkg::KC_GUI_TOGGLE, hkep_pkg::KC_PATTERN_LEFT,
                     hkep_pkg::KC_PATTERN_RIGHT, hkep_pkg::KC_BRIGHT_DOWN,
                     hkep_pkg::KC_BRIGHT_UP, hkep_pkg::KC_FN,
                     hkep_pkg::KC_FN_LOCK, hkep_pkg::KC_PATTERN_RIGHT};
        pick       = $urandom_range(0, 99);
        pool_key   = 8'h04 + 8'($urandom_range(0, 7));
        ev.pressed = 1'($urandom_range(0, 1));
        if (pick < 40)
            ev.keycode = {8'h00, pool_key};
        else if (pick < 48)
        begin
            case ($urandom_range(0, 3))
                0: ev.keycode = 16'($urandom);
                1: ev.keycode = 16'h0000;
                2: ev.keycode = {8'($urandom_range(1, 255)), 8'h00};
                default: ev.keycode = {8'($urandom_range(1, 255)), pool_key};
            endcase
        end
        else if (pick < 63)
            ev.keycode = hkep_pkg::KC_MOD_FIRST + 16'($urandom_range(0, 7));
        else if (pick < 73)
            ev.keycode = hkep_pkg::KC_MEDIA_FIRST + 16'($urandom_range(0, 6));
        else
        begin
            ev.keycode = specials[$urandom_range(0, 9)];
            ev.pressed = ($urandom_range(0, 9) < 7);
        end
        return ev;
    endfunction

    // Receiver: stalls for a drawn number of cycles before each word.
    initial
    begin
        int n;
        out_stall   = 1'b0;
        recv_steady = 1'b0;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                recv_steady = !recv_steady;
            n = recv_steady ? 0 : $urandom_range(0, 12);
            @(negedge clk);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            tracker.check_report(out_word);
        end
    end

    initial
    begin
        hkep_pkg::event_t opening [$];
        logic [4:0]       settings [8];
        tracker     = new();
        send_steady = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        settings    = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd17,
                        5'($urandom_range(1, 16)), hkep_pkg::PATTERN_COUNT_RESET};
        opening = '{
            {hkep_pkg::KC_PATTERN_LEFT, 1'b1},
            {hkep_pkg::KC_MEDIA_FIRST, 1'b1},
            {hkep_pkg::KC_MEDIA_LAST, 1'b1},
            {hkep_pkg::KC_MEDIA_FIRST, 1'b0},
            {hkep_pkg::KC_ANIM_TOGGLE, 1'b1},
            {hkep_pkg::KC_MACRO, 1'b1},
            {hkep_pkg::KC_FN, 1'b1},
            {hkep_pkg::KC_FN, 1'b0},
            {hkep_pkg::KC_FN_LOCK, 1'b1},
            {hkep_pkg::KC_MOD_FIRST + 16'(hkep_pkg::MOD_LEFT_GUI), 1'b1},
            {hkep_pkg::KC_GUI_TOGGLE, 1'b1},
            {hkep_pkg::KC_MOD_LAST, 1'b1},
            {hkep_pkg::KC_MOD_FIRST, 1'b1},
            {hkep_pkg::KC_PATTERN_RIGHT, 1'b1},
            {hkep_pkg::KC_PATTERN_RIGHT, 1'b1},
            {hkep_pkg::KC_PATTERN_RIGHT, 1'b1},
            {hkep_pkg::KC_BRIGHT_DOWN, 1'b1},
            {hkep_pkg::KC_BRIGHT_UP, 1'b1},
            {16'hFFFF, 1'b1},
            {16'h0100, 1'b1},
            {16'h0000, 1'b0},
            {16'hFFFF, 1'b0},
            {16'h0004, 1'b1},
            {16'h0005, 1'b1},
            {16'h0004, 1'b1},
            {16'h0006, 1'b1},
            {16'h0007, 1'b1},
            {16'h0008, 1'b1},
            {16'h0004, 1'b0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (settings[p])
        begin
            drain();
            write_pattern_count(settings[p]);
            if (p == 0)
                foreach (opening[k])
                    send_event(opening[k]);
            repeat (RANDOM_PER_PHASE)
                send_event(random_event());
        end
        drain();
        repeat (10) @(posedge clk);

        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
